// File: hdl/mcac_pkg.sv
// ----------------------------------------------------------------------------
// mcac_pkg
// Shared types and constants for the cross-axis compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcac_pkg;

  localparam int RAW_W  = 16;
  localparam int ADJ_W  = 33;
  localparam int PROD_W = 49;
  localparam int DET_W  = 50;
  localparam int DEN_W  = 54;
  localparam int ACC_W  = 82;
  localparam int MAG_W  = 48;
  localparam int MAT_W  = 64;
  localparam int NWORDS = 9;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [3:0] LAST_WORD = 4'd8;

  // operand word indices of the adjugate terms, two terms per entry
  localparam logic [3:0] ADJ_IA [18] = '{
    4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
    4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1
  };
  localparam logic [3:0] ADJ_IB [18] = '{
    4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
    4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3
  };

  typedef struct packed {
    logic             en;
    logic [3:0]       idx;
    logic [MAT_W-1:0] data;
  } mat_wr_t;

  typedef struct packed {
    logic busy;
    logic valid;
    logic singular;
  } build_stat_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             clip;
    logic [MAG_W-1:0] mag;
  } lane_res_t;

endpackage

`default_nettype wire

// File: hdl/mcac_if.sv
// ----------------------------------------------------------------------------
// mcac channel interfaces
// Request channel (loads and samples) and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcac_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         index;
  logic signed [15:0] coef;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic signed [15:0] raw_z;

  modport source (output valid, kind, index, coef, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, kind, index, coef, raw_x, raw_y, raw_z, output ready);
endinterface

interface mcac_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] mag_x;
  logic signed [47:0] mag_y;
  logic signed [47:0] mag_z;
  logic               compensated;
  logic               clipped;
  logic               degenerate;

  modport source (output valid, mag_x, mag_y, mag_z, compensated, clipped, degenerate,
                  input ready);
  modport sink   (input valid, mag_x, mag_y, mag_z, compensated, clipped, degenerate,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/mcac_build.sv
// ----------------------------------------------------------------------------
// mcac_build
// Holds the cross-axis words and builds the compensation matrix:
// adjugate and determinant on one shared multiplier, then a bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mcac_build #(
  parameter int MATRIX_FRAC_BITS = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   ld_en,
  input  wire  [3:0]            ld_idx,
  input  wire  [15:0]           ld_data,
  output mcac_pkg::mat_wr_t     mat_wr,
  output mcac_pkg::build_stat_t stat
);
  import mcac_pkg::*;

  localparam int NW  = (MATRIX_FRAC_BITS + 36 > 65) ? MATRIX_FRAC_BITS + 36 : 65;
  localparam int BCW = $clog2(NW + 1);
  localparam logic [MAT_W-1:0] DIAG =
    MAT_W'(((66'd1 << MATRIX_FRAC_BITS) * 2 + 50) / 100);
  localparam logic [MAT_W-1:0] SMAX = {1'b0, {(MAT_W-1){1'b1}}};
  localparam logic [MAT_W-1:0] SMIN = {1'b1, {(MAT_W-1){1'b0}}};

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ADJ   = 8'b0000_0010,
    S_DET   = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_SETUP = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_FALL  = 8'b1000_0000
  } state_t;

  state_t                    state;
  logic signed [15:0]        cross_words [NWORDS];
  logic signed [ADJ_W-1:0]   adj_mem [NWORDS];
  logic [4:0]                term;
  logic [1:0]                sub;
  logic [3:0]                k;
  logic signed [15:0]        ra;
  logic signed [ADJ_W-1:0]   rb;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ADJ_W-1:0]   adj_acc;
  logic signed [DET_W-1:0]   det;
  logic [DEN_W-1:0]          den;
  logic [NW-1:0]             num;
  logic [NW-1:0]             quo;
  logic [DEN_W-1:0]          rem;
  logic [BCW-1:0]            bitcnt;
  logic                      neg;
  logic                      cof_zero;
  logic                      valid;
  logic                      singular;

  logic [3:0]                y_addr;
  logic [3:0]                adj_addr;
  logic signed [15:0]        y_rd;
  logic signed [ADJ_W-1:0]   adj_rd;
  logic signed [ADJ_W-1:0]   adj_next;
  logic [DET_W-1:0]          det_abs;
  logic [ADJ_W-1:0]          cof_abs;
  logic [DEN_W:0]            rem_sh;
  logic                      qbit;
  logic [MAT_W-1:0]          entry;

  always_comb begin
    if (state == S_ADJ) begin
      y_addr = (sub == 2'd0) ? ADJ_IA[term] : ADJ_IB[term];
    end else begin
      y_addr = {2'b00, term[1:0]};
    end
    adj_addr = (state == S_DET) ? {2'b00, term[1:0]} + {1'b0, term[1:0], 1'b0} : k;
    y_rd     = cross_words[y_addr];
    adj_rd   = adj_mem[adj_addr];
    adj_next = term[0] ? adj_acc - ADJ_W'(prod) : ADJ_W'(prod);
    det_abs  = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
    cof_abs  = adj_rd[ADJ_W-1] ? ADJ_W'(-adj_rd) : ADJ_W'(adj_rd);
    rem_sh   = {rem, num[NW-1]};
    qbit     = (rem_sh >= {1'b0, den});
    if (cof_zero) begin
      entry = '0;
    end else if (neg) begin
      entry = (|quo[NW-1:MAT_W-1]) ? SMIN : MAT_W'(-quo[MAT_W-1:0]);
    end else begin
      entry = (|quo[NW-1:MAT_W-1]) ? SMAX : quo[MAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NWORDS; i++) begin
        cross_words[i] <= '0;
      end
    end else if (ld_en && ld_idx <= LAST_WORD) begin
      cross_words[ld_idx] <= ld_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ADJ && sub == 2'd3 && term[0]) begin
      adj_mem[term[4:1]] <= adj_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_wr.en <= 1'b0;
      state    <= S_IDLE;
      term     <= '0;
      sub      <= '0;
      k        <= '0;
      valid    <= 1'b0;
      singular <= 1'b0;
    end else begin
      mat_wr.en <= (state == S_WRITE) || (state == S_FALL);
      unique case (state)
        S_IDLE: begin
          term <= '0;
          sub  <= '0;
          if (ld_en && ld_idx == LAST_WORD) begin
            state <= S_ADJ;
          end
        end
        S_ADJ: begin
          sub <= sub + 2'd1;
          case (sub)
            2'd0: ra <= y_rd;
            2'd1: rb <= ADJ_W'(y_rd);
            2'd2: prod <= ra * rb;
            default: begin
              adj_acc <= adj_next;
              if (term == 5'd17) begin
                term  <= '0;
                det   <= '0;
                state <= S_DET;
              end else begin
                term <= term + 5'd1;
              end
            end
          endcase
        end
        S_DET: begin
          sub <= sub + 2'd1;
          case (sub)
            2'd0: begin
              ra <= y_rd;
              rb <= adj_rd;
            end
            2'd1: ;
            2'd2: prod <= ra * rb;
            default: begin
              det <= det + DET_W'(prod);
              if (term == 5'd2) begin
                state <= S_CHECK;
              end else begin
                term <= term + 5'd1;
              end
            end
          endcase
        end
        S_CHECK: begin
          k   <= '0;
          den <= (DEN_W'(det_abs) << 5) - (DEN_W'(det_abs) << 1);
          state <= (det == '0) ? S_FALL : S_SETUP;
        end
        S_SETUP: begin
          num      <= (NW'(cof_abs) << (MATRIX_FRAC_BITS + 2)) + NW'(den >> 1);
          neg      <= adj_rd[ADJ_W-1] ^ det[DET_W-1];
          cof_zero <= (adj_rd == '0);
          rem      <= '0;
          quo      <= '0;
          bitcnt   <= BCW'(NW);
          state    <= S_DIV;
        end
        S_DIV: begin
          rem    <= qbit ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
          quo    <= {quo[NW-2:0], qbit};
          num    <= {num[NW-2:0], 1'b0};
          bitcnt <= bitcnt - BCW'(1);
          if (bitcnt == BCW'(1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          mat_wr.idx  <= k;
          mat_wr.data <= entry;
          if (k == LAST_WORD) begin
            valid    <= 1'b1;
            singular <= 1'b0;
            state    <= S_IDLE;
          end else begin
            k     <= k + 4'd1;
            state <= S_SETUP;
          end
        end
        S_FALL: begin
          mat_wr.idx  <= k;
          mat_wr.data <= (k == 4'd0 || k == 4'd4 || k == 4'd8) ? DIAG : '0;
          if (k == LAST_WORD) begin
            valid    <= 1'b1;
            singular <= 1'b1;
            state    <= S_IDLE;
          end else begin
            k <= k + 4'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.busy     = (state != S_IDLE);
  assign stat.valid    = valid;
  assign stat.singular = singular;

endmodule

`default_nettype wire

// File: hdl/mcac_lane.sv
// ----------------------------------------------------------------------------
// mcac_lane
// One matrix row: multiply-accumulate of A-row by the raw vector in 32-bit
// halves, then round and saturate to the output format.
// ----------------------------------------------------------------------------
`default_nettype none

module mcac_lane #(
  parameter int LANE             = 0,
  parameter int MATRIX_FRAC_BITS = 32,
  parameter int OUT_FRAC_BITS    = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  mcac_pkg::mat_wr_t   mat_wr,
  input  wire                 start,
  input  wire  [15:0]         raw0,
  input  wire  [15:0]         raw1,
  input  wire  [15:0]         raw2,
  output mcac_pkg::lane_res_t res
);
  import mcac_pkg::*;

  localparam int SH = MATRIX_FRAC_BITS - OUT_FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = (SH > 0) ? (ACC_W'(1) << ((SH > 0) ? SH - 1 : 0)) : '0;
  localparam logic [3:0] BASE = 4'(3 * LANE);

  logic [MAT_W-1:0]         row [3];
  logic signed [15:0]       raw [3];
  logic [3:0]               cnt;
  logic                     busy;
  logic                     phi;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;

  logic [1:0]               sel;
  logic [MAT_W-1:0]         a_sel;
  logic signed [32:0]       a_part;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  shifted;
  logic                     fits;

  always_comb begin
    sel      = (cnt[2:1] == 2'd3) ? 2'd0 : cnt[2:1];
    a_sel    = row[sel];
    a_part   = cnt[0] ? {a_sel[63], a_sel[63:32]} : {1'b0, a_sel[31:0]};
    prod_ext = ACC_W'(prod);
    shifted  = rnd >>> SH;
    fits     = (shifted[ACC_W-1:MAG_W-1] == {(ACC_W-MAG_W+1){shifted[MAG_W-1]}});
  end

  always_ff @(posedge clk) begin
    if (mat_wr.en && mat_wr.idx >= BASE && mat_wr.idx < BASE + 4'd3) begin
      row[2'(mat_wr.idx - BASE)] <= mat_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      res.done <= 1'b0;
    end else begin
      res.done <= !start && busy && (cnt == 4'd8);
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        acc    <= '0;
        raw[0] <= raw0;
        raw[1] <= raw1;
        raw[2] <= raw2;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt < 4'd6) begin
          prod <= a_part * raw[sel];
          phi  <= cnt[0];
        end
        if (cnt >= 4'd1 && cnt <= 4'd6) begin
          acc <= acc + (phi ? (prod_ext <<< 32) : prod_ext);
        end
        if (cnt == 4'd7) begin
          rnd <= acc + HALF;
        end
        if (cnt == 4'd8) begin
          busy     <= 1'b0;
          res.clip <= !fits;
          if (fits) begin
            res.mag <= shifted[MAG_W-1:0];
          end else begin
            res.mag <= shifted[ACC_W-1] ? {1'b1, {(MAG_W-1){1'b0}}}
                                        : {1'b0, {(MAG_W-1){1'b1}}};
          end
        end
      end
    end
  end

  assign res.busy = busy;

endmodule

`default_nettype wire

// File: hdl/magnetometer_cross_axis_compensation.sv
// ----------------------------------------------------------------------------
// magnetometer_cross_axis_compensation
// Three-axis cross-axis compensation: A = adj(Y)*2/(15*det Y) applied to raw
// counts, result in mGauss with OUT_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Loading word 8 starts the matrix build, during which no request is taken: the
// adjugate and then the determinant on one shared multiplier, a check step, then
// per entry a setup step, a bit-serial divider of MATRIX_FRAC_BITS+36 steps (at
// least 65) and a write step, for nine entries; a zero determinant instead writes
// I/50. A sample runs through three row lanes in parallel, 6 multiply-accumulate
// steps each on a 33x16 multiplier, plus round and saturate: the next request is
// taken only once the result has moved on, which waits while the output register
// still holds a result that the receiver has not taken.
`default_nettype none

module magnetometer_cross_axis_compensation #(
  parameter int OUT_FRAC_BITS    = 16,
  parameter int MATRIX_FRAC_BITS = 32
) (
  input wire         clk,
  input wire         rst,
  mcac_in_if.sink    in_chan,
  mcac_out_if.source out_chan
);
  import mcac_pkg::*;

  mat_wr_t     mat_wr;
  build_stat_t stat;
  lane_res_t   res [3];

  logic        accept;
  logic        ld_en;
  logic        start;
  logic        start_q;
  logic        pend;
  logic        out_valid;
  logic [15:0] raw_hold [3];

  assign accept = in_chan.valid && in_chan.ready;
  assign ld_en  = accept && (in_chan.kind == KIND_LOAD);
  assign start  = accept && (in_chan.kind == KIND_SAMPLE);
  assign in_chan.ready = !stat.busy && !res[0].busy && !res[0].done && !start_q && !pend;

  mcac_build #(
    .MATRIX_FRAC_BITS(MATRIX_FRAC_BITS)
  ) u_build (
    .clk    (clk),
    .rst    (rst),
    .ld_en  (ld_en),
    .ld_idx (in_chan.index),
    .ld_data(in_chan.coef),
    .mat_wr (mat_wr),
    .stat   (stat)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    mcac_lane #(
      .LANE            (g),
      .MATRIX_FRAC_BITS(MATRIX_FRAC_BITS),
      .OUT_FRAC_BITS   (OUT_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .mat_wr(mat_wr),
      .start (start),
      .raw0  (in_chan.raw_x),
      .raw1  (in_chan.raw_y),
      .raw2  (in_chan.raw_z),
      .res   (res[g])
    );
  end

  // merge stage
  always_ff @(posedge clk) begin
    if (start) begin
      raw_hold[0] <= in_chan.raw_x;
      raw_hold[1] <= in_chan.raw_y;
      raw_hold[2] <= in_chan.raw_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_q   <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start_q <= start;
      if (res[0].done) begin
        pend <= 1'b1;
      end
      if (pend && (!out_valid || out_chan.ready)) begin
        pend      <= 1'b0;
        out_valid <= 1'b1;
        if (stat.valid) begin
          out_chan.mag_x       <= res[0].mag;
          out_chan.mag_y       <= res[1].mag;
          out_chan.mag_z       <= res[2].mag;
          out_chan.compensated <= 1'b1;
          out_chan.clipped     <= res[0].clip | res[1].clip | res[2].clip;
          out_chan.degenerate  <= stat.singular;
        end else begin
          out_chan.mag_x       <= MAG_W'({{(MAG_W-16){raw_hold[0][15]}}, raw_hold[0]}
                                         << OUT_FRAC_BITS);
          out_chan.mag_y       <= MAG_W'({{(MAG_W-16){raw_hold[1][15]}}, raw_hold[1]}
                                         << OUT_FRAC_BITS);
          out_chan.mag_z       <= MAG_W'({{(MAG_W-16){raw_hold[2][15]}}, raw_hold[2]}
                                         << OUT_FRAC_BITS);
          out_chan.compensated <= 1'b0;
          out_chan.clipped     <= 1'b0;
          out_chan.degenerate  <= 1'b0;
        end
      end else if (out_valid && out_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_chan.valid = out_valid;

endmodule

`default_nettype wire

// File: tb/magnetometer_cross_axis_compensation_test.sv
// ----------------------------------------------------------------------------
// magnetometer_cross_axis_compensation_test
// Drives word loads and raw samples through the request channel with bursty
// sending and receiver stalls. A behavioral predictor builds the compensation
// matrix exactly and computes each expected result; results are checked in
// order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_cross_axis_compensation_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mcac_pkg::*;

  localparam int OFB = 16;
  localparam int MFB = 32;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        kind;
    logic [3:0]  index;
    logic [15:0] coef;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] rz;
  } request_t;

  typedef struct packed {
    logic [47:0] mx;
    logic [47:0] my;
    logic [47:0] mz;
    logic        comp;
    logic        clip;
    logic        degen;
  } field_t;

  typedef struct {
    request_t req;
    bit       has_exp;
    field_t   exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  mcac_in_if  in_chan ();
  mcac_out_if out_chan ();

  magnetometer_cross_axis_compensation #(
    .OUT_FRAC_BITS(OFB), .MATRIX_FRAC_BITS(MFB)
  ) DUT (
    .clk(clk), .rst(rst), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0]  words [9];
  logic signed [63:0]  amat [9];
  bit                  mvalid;
  bit                  msing;

  field_t expected_fields [$];
  int     errors;
  longint cycles;
  bit     send_idle;

  function automatic logic signed [63:0] divide_entry(logic signed [127:0] cof,
                                                      logic signed [127:0] det);
    logic signed [127:0] n, d, q;
    bit neg;
    neg = (cof < 0) != (det < 0);
    n = (cof < 0) ? -cof : cof;
    d = (det < 0) ? -det : det;
    q = ((n <<< (MFB + 2)) + 15 * d) / (30 * d);
    if (neg) q = -q;
    if (q > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (q < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return q[63:0];
  endfunction

  task automatic build_compensation();
    logic signed [127:0] y [9];
    logic signed [127:0] adj [9];
    logic signed [127:0] det;
    for (int k = 0; k < 9; k++) y[k] = words[k];
    adj[0] = y[4]*y[8] - y[5]*y[7];
    adj[1] = y[2]*y[7] - y[1]*y[8];
    adj[2] = y[1]*y[5] - y[2]*y[4];
    adj[3] = y[5]*y[6] - y[3]*y[8];
    adj[4] = y[0]*y[8] - y[2]*y[6];
    adj[5] = y[2]*y[3] - y[0]*y[5];
    adj[6] = y[3]*y[7] - y[4]*y[6];
    adj[7] = y[1]*y[6] - y[0]*y[7];
    adj[8] = y[0]*y[4] - y[1]*y[3];
    det = y[0]*adj[0] + y[1]*adj[3] + y[2]*adj[6];
    if (det == 0) begin
      for (int k = 0; k < 9; k++)
        amat[k] = (k % 4 == 0) ? 64'((((128'sd1 <<< MFB) * 2) + 50) / 100) : 64'sd0;
      msing = 1'b1;
    end else begin
      for (int k = 0; k < 9; k++) amat[k] = divide_entry(adj[k], det);
      msing = 1'b0;
    end
    mvalid = 1'b1;
  endtask

  // returns 1 when a result is produced
  task automatic predict_field(input request_t r, output bit produced, output field_t f);
    logic signed [127:0] raw [3];
    logic signed [127:0] acc;
    logic [47:0] outv [3];
    bit clip;
    produced = 1'b0;
    f = '0;
    if (r.kind == KIND_LOAD) begin
      if (r.index <= LAST_WORD) begin
        words[r.index] = r.coef;
        if (r.index == LAST_WORD) build_compensation();
      end
      return;
    end
    produced = 1'b1;
    raw[0] = $signed(r.rx);
    raw[1] = $signed(r.ry);
    raw[2] = $signed(r.rz);
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!mvalid) begin
        outv[i] = 48'(raw[i] <<< OFB);
      end else begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += 128'(amat[i*3+j]) * raw[j];
        acc = (acc + (128'sd1 <<< (MFB - OFB - 1))) >>> (MFB - OFB);
        if (acc > 128'sh7FFF_FFFF_FFFF) begin
          outv[i] = 48'h7FFF_FFFF_FFFF;
          clip = 1'b1;
        end else if (acc < -128'sh8000_0000_0000) begin
          outv[i] = 48'h8000_0000_0000;
          clip = 1'b1;
        end else begin
          outv[i] = acc[47:0];
        end
      end
    end
    f.mx = outv[0];
    f.my = outv[1];
    f.mz = outv[2];
    f.comp = mvalid;
    f.clip = mvalid && clip;
    f.degen = mvalid && msing;
  endtask

  function automatic request_t load_req(int idx, logic [15:0] c);
    request_t r;
    r = '0;
    r.kind = KIND_LOAD;
    r.index = 4'(idx);
    r.coef = c;
    r.rx = 16'($urandom);
    return r;
  endfunction

  function automatic request_t sample_req(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    request_t r;
    r = '0;
    r.kind = KIND_SAMPLE;
    r.index = 4'($urandom);
    r.coef = 16'($urandom);
    r.rx = x;
    r.ry = y;
    r.rz = z;
    return r;
  endfunction

  function automatic field_t pass_field(logic signed [15:0] x, logic signed [15:0] y,
                                        logic signed [15:0] z);
    field_t f;
    f = '0;
    f.mx = 48'(x) << OFB;
    f.my = 48'(y) << OFB;
    f.mz = 48'(z) << OFB;
    return f;
  endfunction

  function automatic field_t fallback_field(logic signed [15:0] x, logic signed [15:0] y,
                                            logic signed [15:0] z);
    field_t f;
    f = '0;
    f.comp = 1'b1;
    f.degen = 1'b1;
    f.mx = 48'((64'sd85899346 * x + (64'sd1 <<< 15)) >>> 16);
    f.my = 48'((64'sd85899346 * y + (64'sd1 <<< 15)) >>> 16);
    f.mz = 48'((64'sd85899346 * z + (64'sd1 <<< 15)) >>> 16);
    return f;
  endfunction

  task automatic send_request(input request_t r, input bit has_exp, input field_t typed);
    bit produced;
    field_t f;
    if (send_idle) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind  <= r.kind;
    in_chan.index <= r.index;
    in_chan.coef  <= r.coef;
    in_chan.raw_x <= r.rx;
    in_chan.raw_y <= r.ry;
    in_chan.raw_z <= r.rz;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_field(r, produced, f);
    if (produced) begin
      if (has_exp && f !== typed) begin
        errors++;
        if (errors <= 10)
          $display("predictor disagrees with table row: %h vs %h", f, typed);
      end
      expected_fields.push_back(f);
    end
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_fields.size() != 0) @(posedge clk);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_chan.ready <= 1'b0;
    end else if (cycles % 300 < 60) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    field_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (!rst && out_chan.valid && out_chan.ready) begin
      got = {out_chan.mag_x, out_chan.mag_y, out_chan.mag_z,
             out_chan.compensated, out_chan.clipped, out_chan.degenerate};
      if (expected_fields.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_fields.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp x=%h y=%h z=%h c=%b k=%b d=%b got x=%h y=%h z=%h c=%b k=%b d=%b",
                     want.mx, want.my, want.mz, want.comp, want.clip, want.degen,
                     got.mx, got.my, got.mz, got.comp, got.clip, got.degen);
        end
      end
    end
  end

  task automatic load_matrix(input logic [15:0] m [9]);
    for (int k = 0; k < 9; k++) send_request(load_req(k, m[k]), 1'b0, '0);
  endtask

  initial begin
    row_t table_rows [$];
    logic [15:0] mat [9];
    request_t r;
    int burst;
    errors = 0;
    cycles = 0;
    send_idle = 1'b0;
    mvalid = 1'b0;
    msing = 1'b0;
    for (int k = 0; k < 9; k++) begin
      words[k] = '0;
      amat[k] = (k % 4 == 0) ? (64'sd1 <<< MFB) : 64'sd0;
    end
    in_chan.valid <= 1'b0;
    in_chan.kind <= KIND_LOAD;
    in_chan.index <= '0;
    in_chan.coef <= '0;
    in_chan.raw_x <= '0;
    in_chan.raw_y <= '0;
    in_chan.raw_z <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    table_rows.push_back('{sample_req(16'h7FFF, 16'h8000, 16'h0000), 1'b1,
                           pass_field(16'sh7FFF, -16'sh8000, 16'sh0)});
    table_rows.push_back('{sample_req(16'hFFFF, 16'h0001, 16'h5A5A), 1'b1,
                           pass_field(-16'sd1, 16'sd1, 16'sh5A5A)});
    table_rows.push_back('{load_req(9, 16'h1234), 1'b0, '0});
    table_rows.push_back('{load_req(15, 16'hFFFF), 1'b0, '0});
    table_rows.push_back('{load_req(3, 16'h0100), 1'b0, '0});
    table_rows.push_back('{sample_req(16'h0010, 16'h0020, 16'h0030), 1'b1,
                           pass_field(16'sh10, 16'sh20, 16'sh30)});
    // word 8 with others mostly zero: singular fallback
    table_rows.push_back('{load_req(8, 16'h0000), 1'b0, '0});
    table_rows.push_back('{sample_req(16'h7FFF, 16'h8000, 16'h0001), 1'b1,
                           fallback_field(16'sh7FFF, -16'sh8000, 16'sh1)});
    table_rows.push_back('{sample_req(16'h0000, 16'hFFFF, 16'h0000), 1'b1,
                           fallback_field(16'sh0, -16'sd1, 16'sh0)});
    foreach (table_rows[i]) send_request(table_rows[i].req, table_rows[i].has_exp,
                                         table_rows[i].exp);
    drain_results();

    // identity-like, tiny, extreme matrices
    mat = '{16'd20, 16'd0, 16'd0, 16'd0, 16'd20, 16'd0, 16'd0, 16'd0, 16'd20};
    load_matrix(mat);
    send_request(sample_req(16'h7FFF, 16'h8000, 16'h1234), 1'b0, '0);
    mat = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1};
    load_matrix(mat);
    send_request(sample_req(16'h7FFF, 16'h8000, 16'hFFFF), 1'b0, '0);
    send_request(load_req(0, 16'h7FFF), 1'b0, '0);
    send_request(sample_req(16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0, '0);
    mat = '{16'h8000, 16'h7FFF, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF,
            16'h0001, 16'hFFFF, 16'h7FFF};
    load_matrix(mat);
    send_request(sample_req(16'h8000, 16'h8000, 16'h8000), 1'b0, '0);
    drain_results();

    // random part
    for (int n = 0; n < 450; ) begin
      burst = $urandom_range(1, 20);
      send_idle = 1'b0;
      for (int b = 0; b < burst && n < 450; b++) begin
        send_idle = ($urandom_range(0, 5) == 0);
        case ($urandom_range(0, 19))
          0: begin
            for (int k = 0; k < 9; k++) begin
              case ($urandom_range(0, 3))
                0: mat[k] = 16'($urandom);
                1: mat[k] = 16'($signed($urandom_range(0, 60)) - 30);
                2: mat[k] = (k % 4 == 0) ? 16'($urandom_range(15, 25)) : 16'($urandom_range(0, 3));
                default: mat[k] = (k % 4 == 0) ? 16'd20 : 16'd0;
              endcase
            end
            if ($urandom_range(0, 4) == 0) mat[$urandom_range(0, 2) * 3 + 2] = 16'd0;
            load_matrix(mat);
            n += 9;
          end
          1: begin
            send_request(load_req($urandom_range(0, 15), 16'($urandom)), 1'b0, '0);
            n++;
          end
          default: begin
            case ($urandom_range(0, 3))
              0: r = sample_req(16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000),
                                16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000),
                                16'($urandom));
              1: r = sample_req(16'($signed($urandom_range(0, 2000)) - 1000),
                                16'($signed($urandom_range(0, 2000)) - 1000),
                                16'($signed($urandom_range(0, 2000)) - 1000));
              default: r = sample_req(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            send_request(r, 1'b0, '0);
            n++;
          end
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        drain_results();
      end else begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_fields.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
